[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define SMON_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("smon: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted
`define SMON_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("smon: next-cycle check failed");

// Next-cycle implication that also runs through reset
`define SMON_ASSERT_RST(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) (a) |=> (c)) \
        else $error("smon: reset check failed");

`endif

[design/smon_pkg.sv]
package smon_pkg;

    // Fixed field widths
    localparam int STAGE_W   = 3;
    localparam int LEVEL_W   = 24;
    localparam int CNT_W     = 32;
    localparam int ENERGY_W  = 64;
    localparam int CFG_IDX_W = 2;

    // Register reset values, Q3.20: 1.0 and 0.5
    localparam logic               ENABLE_RESET = 1'b1;
    localparam logic [LEVEL_W-1:0] CLIP_RESET   = 24'd1048576;
    localparam logic [LEVEL_W-1:0] JUMP_RESET   = 24'd524288;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE     = 2'd0,
        REG_CLIP_LEVEL = 2'd1,
        REG_JUMP_LEVEL = 2'd2
    } t_cfg_reg;

    // Control carried alongside the registered sample
    typedef struct packed {
        logic               valid;
        logic               clipped;
        logic [STAGE_W-1:0] stage;
    } t_s1_ctl;

    // Counter increment that sticks at all ones
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

[design/smon_if.sv]
// Sample input channel
interface smon_in_if import smon_pkg::*; #(parameter int SAMPLE_BITS = 24) ();
    logic                          valid;
    logic                          ready;
    logic [STAGE_W-1:0]            stage;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, stage, sample, input ready);
    modport sink   (input valid, stage, sample, output ready);
endinterface

// Statistics result channel
interface smon_out_if import smon_pkg::*; #(parameter int SAMPLE_BITS = 24) ();
    logic                   valid;
    logic                   ready;
    logic [STAGE_W-1:0]     stage_out;
    logic [SAMPLE_BITS-2:0] peak_positive;
    logic [SAMPLE_BITS-1:0] peak_negative;
    logic [ENERGY_W-1:0]    energy_sum;
    logic [CNT_W-1:0]       clipped_count;
    logic [CNT_W-1:0]       jump_count;
    logic [CNT_W-1:0]       total_count;

    modport source (output valid, stage_out, peak_positive, peak_negative, energy_sum,
                    clipped_count, jump_count, total_count, input ready);
    modport sink   (input valid, stage_out, peak_positive, peak_negative, energy_sum,
                    clipped_count, jump_count, total_count, output ready);
endinterface

// Configuration write channel
interface smon_cfg_if import smon_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LEVEL_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/multi_stage_signal_level_monitor.sv]
// Per-stage signal level monitor. A sample is held in the input register, and its updated
// statistics load into the result register once the result slot is free.
// Throughput: one sample per cycle while results are taken; a waiting result lets one more
// sample into the input register, then holds the input off.
// Reset (synchronous, active low) clears all per-stage statistics at once and
// restores enable = 1, clip level = 1.0, jump level = 0.5.
module multi_stage_signal_level_monitor import smon_pkg::*; #(
    parameter int NUM_STAGES  = 7,
    parameter int SAMPLE_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smon_in_if.sink    i_in,
    smon_out_if.source o_out,
    smon_cfg_if.sink   i_cfg
);

    logic               r_enable;
    logic [LEVEL_W-1:0] r_clip_level;
    logic [LEVEL_W-1:0] r_jump_level;

    t_s1_ctl                       w_ctl;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic [SAMPLE_BITS-1:0]        w_mag;
    logic [2*SAMPLE_BITS-1:0]      w_square;
    logic                          w_free;
    logic                          w_adv;
    logic                          w_take;

    // Configuration registers; writes are always taken outside reset
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= ENABLE_RESET;
            r_clip_level <= CLIP_RESET;
            r_jump_level <= JUMP_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_ENABLE:     r_enable     <= i_cfg.data[0];
                REG_CLIP_LEVEL: r_clip_level <= i_cfg.data;
                REG_JUMP_LEVEL: r_jump_level <= i_cfg.data;
                default:        ;
            endcase
        end
    end

    // Pipeline flow: the registered sample moves on when the result slot is free
    assign w_adv      = w_ctl.valid && w_free;
    assign i_in.ready = i_rst_n && (!w_ctl.valid || w_free);
    assign w_take     = i_in.valid && i_in.ready;

    smon_front #(
        .NUM_STAGES  (NUM_STAGES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_adv        (w_adv),
        .i_stage      (i_in.stage),
        .i_sample     (i_in.sample),
        .i_enable     (r_enable),
        .i_clip_level (r_clip_level),
        .o_ctl        (w_ctl),
        .o_sample     (w_sample),
        .o_mag        (w_mag),
        .o_square     (w_square)
    );

    smon_stats #(
        .NUM_STAGES  (NUM_STAGES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_ctl        (w_ctl),
        .i_sample     (w_sample),
        .i_mag        (w_mag),
        .i_square     (w_square),
        .i_jump_level (r_jump_level),
        .o_free       (w_free),
        .o_out        (o_out)
    );

endmodule

[design/smon_front.sv]
module smon_front import smon_pkg::*; #(
    parameter int NUM_STAGES  = 7,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic                          i_adv,
    input  logic [STAGE_W-1:0]            i_stage,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_enable,
    input  logic [LEVEL_W-1:0]            i_clip_level,
    output t_s1_ctl                       o_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic [SAMPLE_BITS-1:0]        o_mag,
    output logic [2*SAMPLE_BITS-1:0]      o_square
);

    localparam int CLIP_CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    logic [SAMPLE_BITS-1:0]   w_raw;
    logic [SAMPLE_BITS-1:0]   w_mag;
    logic [2*SAMPLE_BITS-1:0] w_square;
    logic                     w_in_range;
    logic                     w_clipped;

    logic                          r_valid;
    logic                          r_clipped;
    logic [STAGE_W-1:0]            r_stage;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0]        r_mag;
    logic [2*SAMPLE_BITS-1:0]      r_square;

    // Magnitude; the most negative code maps to 2^(SAMPLE_BITS-1)
    assign w_raw      = i_sample;
    assign w_mag      = w_raw[SAMPLE_BITS-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_square   = w_mag * w_mag;
    assign w_in_range = (32'(i_stage) < NUM_STAGES);
    assign w_clipped  = (CLIP_CMP_W'(w_mag) >= CLIP_CMP_W'(i_clip_level));

    // Input register: disabled or out-of-range samples leave no item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= i_enable && w_in_range;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
        if (i_take) begin
            r_clipped <= w_clipped;
            r_stage   <= i_stage;
            r_sample  <= i_sample;
            r_mag     <= w_mag;
            r_square  <= w_square;
        end
    end

    assign o_ctl    = '{valid: r_valid, clipped: r_clipped, stage: r_stage};
    assign o_sample = r_sample;
    assign o_mag    = r_mag;
    assign o_square = r_square;

endmodule

[design/smon_stats.sv]
module smon_stats import smon_pkg::*; #(
    parameter int NUM_STAGES  = 7,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  t_s1_ctl                       i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0]        i_mag,
    input  logic [2*SAMPLE_BITS-1:0]      i_square,
    input  logic [LEVEL_W-1:0]            i_jump_level,
    output logic                          o_free,
    smon_out_if.source                    o_out
);

    // Only stage codes that fit the stage field can ever be hit
    localparam int NUM_LANES  = (NUM_STAGES > (1 << STAGE_W)) ? (1 << STAGE_W) : NUM_STAGES;
    localparam int JUMP_CMP_W = (SAMPLE_BITS + 1 > LEVEL_W) ? SAMPLE_BITS + 1 : LEVEL_W;

    // Per-stage statistics, one lane each
    logic [SAMPLE_BITS-2:0] r_maxp [NUM_LANES];
    logic [SAMPLE_BITS-1:0] r_maxn [NUM_LANES];
    logic [ENERGY_W-1:0]    r_acc  [NUM_LANES];
    logic [CNT_W-1:0]       r_clip [NUM_LANES];
    logic [CNT_W-1:0]       r_jump [NUM_LANES];
    logic [CNT_W-1:0]       r_seen [NUM_LANES];
    logic [SAMPLE_BITS-1:0] r_prev [NUM_LANES];

    logic [SAMPLE_BITS-2:0] w_cur_maxp;
    logic [SAMPLE_BITS-1:0] w_cur_maxn;
    logic [ENERGY_W-1:0]    w_cur_acc;
    logic [CNT_W-1:0]       w_cur_clip;
    logic [CNT_W-1:0]       w_cur_jump;
    logic [CNT_W-1:0]       w_cur_seen;
    logic [SAMPLE_BITS-1:0] w_cur_prev;

    logic [SAMPLE_BITS-1:0] w_val;
    logic                   w_pos;
    logic [ENERGY_W:0]      w_sum;
    logic [SAMPLE_BITS:0]   w_diff;
    logic [SAMPLE_BITS:0]   w_delta;
    logic                   w_jumped;

    logic [SAMPLE_BITS-2:0] n_maxp;
    logic [SAMPLE_BITS-1:0] n_maxn;
    logic [ENERGY_W-1:0]    n_acc;
    logic [CNT_W-1:0]       n_clip;
    logic [CNT_W-1:0]       n_jump;
    logic [CNT_W-1:0]       n_seen;

    logic                   r_out_valid;
    logic [STAGE_W-1:0]     r_stage_out;
    logic [SAMPLE_BITS-2:0] r_top_pos;
    logic [SAMPLE_BITS-1:0] r_top_neg;
    logic [ENERGY_W-1:0]    r_energy;
    logic [CNT_W-1:0]       r_clipped;
    logic [CNT_W-1:0]       r_jumps;
    logic [CNT_W-1:0]       r_total;

    // Select the lane of the registered stage
    always_comb begin
        w_cur_maxp = '0;
        w_cur_maxn = '0;
        w_cur_acc  = '0;
        w_cur_clip = '0;
        w_cur_jump = '0;
        w_cur_seen = '0;
        w_cur_prev = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (i_ctl.stage == STAGE_W'(i)) begin
                w_cur_maxp = w_cur_maxp | r_maxp[i];
                w_cur_maxn = w_cur_maxn | r_maxn[i];
                w_cur_acc  = w_cur_acc  | r_acc[i];
                w_cur_clip = w_cur_clip | r_clip[i];
                w_cur_jump = w_cur_jump | r_jump[i];
                w_cur_seen = w_cur_seen | r_seen[i];
                w_cur_prev = w_cur_prev | r_prev[i];
            end
        end
    end

    assign w_val = i_sample;
    assign w_pos = !w_val[SAMPLE_BITS-1] && (|w_val);

    // Saturating sum of squares: a carry out means the true sum overflowed
    assign w_sum = {1'b0, w_cur_acc} + (ENERGY_W + 1)'(i_square);

    // Step from the previous sample of this stage, one extra bit for the sign
    assign w_diff   = {w_val[SAMPLE_BITS-1], w_val} - {w_cur_prev[SAMPLE_BITS-1], w_cur_prev};
    assign w_delta  = w_diff[SAMPLE_BITS] ? (~w_diff + 1'b1) : w_diff;
    assign w_jumped = (w_cur_seen != '0)
                   && (JUMP_CMP_W'(w_delta) > JUMP_CMP_W'(i_jump_level));

    // Updated statistics of the selected stage
    always_comb begin
        n_maxp = (w_pos && (w_val[SAMPLE_BITS-2:0] > w_cur_maxp))
               ? w_val[SAMPLE_BITS-2:0] : w_cur_maxp;
        n_maxn = (w_val[SAMPLE_BITS-1] && (i_mag > w_cur_maxn)) ? i_mag : w_cur_maxn;
        n_acc  = w_sum[ENERGY_W] ? '1 : w_sum[ENERGY_W-1:0];
        n_clip = i_ctl.clipped ? sat_inc(w_cur_clip) : w_cur_clip;
        n_jump = w_jumped ? sat_inc(w_cur_jump) : w_cur_jump;
        n_seen = sat_inc(w_cur_seen);
    end

    // Lane write-back
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (!i_rst_n) begin
                r_maxp[i] <= '0;
                r_maxn[i] <= '0;
                r_acc[i]  <= '0;
                r_clip[i] <= '0;
                r_jump[i] <= '0;
                r_seen[i] <= '0;
                r_prev[i] <= '0;
            end else if (i_adv && (i_ctl.stage == STAGE_W'(i))) begin
                r_maxp[i] <= n_maxp;
                r_maxn[i] <= n_maxn;
                r_acc[i]  <= n_acc;
                r_clip[i] <= n_clip;
                r_jump[i] <= n_jump;
                r_seen[i] <= n_seen;
                r_prev[i] <= w_val;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_adv) begin
            r_stage_out <= i_ctl.stage;
            r_top_pos   <= n_maxp;
            r_top_neg   <= n_maxn;
            r_energy    <= n_acc;
            r_clipped   <= n_clip;
            r_jumps     <= n_jump;
            r_total     <= n_seen;
        end
    end

    assign o_free = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.stage_out     = r_stage_out;
    assign o_out.peak_positive = r_top_pos;
    assign o_out.peak_negative = r_top_neg;
    assign o_out.energy_sum    = r_energy;
    assign o_out.clipped_count = r_clipped;
    assign o_out.jump_count    = r_jumps;
    assign o_out.total_count   = r_total;

endmodule

[design/smon_checker.sv]
`include "assert_macros.svh"

module smon_checker import smon_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [STAGE_W-1:0] i_out_stage,
    input logic [CNT_W-1:0]   i_out_total
);

    // Stalled result holds
    `SMON_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `SMON_ASSERT_NXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_stage) && $stable(i_out_total))

    // A fresh result is checked to trace back to an earlier sample transfer
    `SMON_ASSERT_IMP(a_out_source, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2))

    // Every result counts at least its own sample
    `SMON_ASSERT_IMP(a_total_nonzero, i_out_valid, i_out_total != '0)

    // Nothing is shown straight after reset
    `SMON_ASSERT_RST(a_reset_empty, !i_rst_n, !i_out_valid)

endmodule

bind multi_stage_signal_level_monitor smon_checker u_smon_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_stage (o_out.stage_out),
    .i_out_total (o_out.total_count)
);
